>>> rtl/core/rlbn_pkg.sv
// shared types, widths and helpers for the rmsd lower bound from norms block
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps
`default_nettype none

package rlbn_pkg;

   localparam int COORD_W   = 20;              // signed q11.8 coordinate
   localparam int MAG_W     = 20;              // magnitude of a coordinate
   localparam int PROD_W    = 2 * MAG_W;       // one square
   localparam int SUM_W     = 52;              // running sum of squared differences
   localparam int ROOT_W    = SUM_W / 2;       // root of the widest operand
   localparam int REM_W     = ROOT_W + 3;      // root remainder after the shift-in
   localparam int COUNT_W   = 11;              // pair counter
   localparam int BOUND_W   = 20;              // result field
   localparam int MAX_ATOMS = 1024;

   // root step counts: a norm square is 40 bits, the mean is treated as full width
   localparam int SHORT_STEPS = PROD_W / 2;
   localparam int LONG_STEPS  = ROOT_W;
   localparam int SHORT_SHIFT = SUM_W - PROD_W;
   localparam int STEP_W      = $clog2(LONG_STEPS + 1);
   localparam int DIV_STEP_W  = $clog2(SUM_W + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_DIFF,
      ST_ACCUM,
      ST_FIN,
      ST_DIV_WAIT,
      ST_MEAN_ROOT,
      ST_OUT
   } seq_state_type;

   // command to the shared root unit
   typedef struct packed {
      logic start;
      logic long_mode;
   } root_cmd_type;

   // magnitude of a two's complement coordinate; the most negative code maps to 2^19
   function automatic logic [MAG_W-1:0] coord_mag(input logic [COORD_W-1:0] v);
      logic [MAG_W-1:0] neg;
      neg = ~v + MAG_W'(1);
      return v[COORD_W-1] ? neg : v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/rmsd_lower_bound_from_norms.sv
// top level: sequencer, shared squarer and accumulator for the rmsd lower bound
// depends on rlbn_pkg, rlbn_sqrt and rlbn_div
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  six q11.8 coordinates, last_atom
// rsp_      out        rsp_valid/rsp_stall  bound_value, atoms_used, overflowed
//
// a pair, accept to accept: per point three squares on the one 20x20 multiplier, a
// root launch and a 20-step root pass; then diff, add, idle
// the last pair adds a start, a 52-step divide, a 26-step root and the result load
// req_stall is high from the accept until the sequencer is back in idle
// reset (synchronous) clears the sequencer, count, sum and overflow flag
// a result parks in the output register; only a second waiting result holds the sequencer

module rmsd_lower_bound_from_norms import rlbn_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [COORD_W-1:0] req_ref_x,
   input  wire logic signed [COORD_W-1:0] req_ref_y,
   input  wire logic signed [COORD_W-1:0] req_ref_z,
   input  wire logic signed [COORD_W-1:0] req_cand_x,
   input  wire logic signed [COORD_W-1:0] req_cand_y,
   input  wire logic signed [COORD_W-1:0] req_cand_z,
   input  wire logic                      req_last_atom,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [BOUND_W-1:0]             rsp_bound_value,
   output logic [COUNT_W-1:0]             rsp_atoms_used,
   output logic                           rsp_overflowed
);

   seq_state_type      state_ff, state_in;

   // latched pair
   logic [COORD_W-1:0] coord_ff [6];
   logic [COORD_W-1:0] coord_in [6];
   logic               last_ff,  last_in;

   // per-point work
   logic               point_ff, point_in;   // 0 reference, 1 candidate
   logic [1:0]         axis_ff,  axis_in;
   logic [PROD_W-1:0]  prod_ff,  prod_in;
   logic [PROD_W-1:0]  nsq_ff,   nsq_in;     // squared norm, q.16
   logic [MAG_W-1:0]   norm_u_ff, norm_u_in;

   // run state
   logic [SUM_W-1:0]   sum_ff,   sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff,   ovf_in;
   logic [BOUND_W-1:0] bound_ff, bound_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BOUND_W-1:0] rsp_bound_ff, rsp_bound_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff,   rsp_ovf_in;

   // shared units
   root_cmd_type       root_cmd;
   logic [SUM_W-1:0]   root_operand;
   logic               root_done;
   logic [ROOT_W-1:0]  root_value;
   logic               div_start;
   logic               div_done;
   logic [SUM_W-1:0]   div_quot;

   logic [MAG_W-1:0]   mul_a;
   logic [MAG_W-1:0]   norm_diff;
   logic [2:0]         coord_sel;
   logic               req_take;

   rlbn_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .cmd     (root_cmd),
      .operand (root_operand),
      .done    (root_done),
      .root    (root_value)
   );

   rlbn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // coordinate for the current square: reference axes first, then candidate
   assign coord_sel = point_ff ? (3'd3 + {1'b0, axis_ff}) : {1'b0, axis_ff};

   // absolute difference of the two norms
   assign norm_diff = (norm_u_ff >= root_value[MAG_W-1:0])
                    ? (norm_u_ff - root_value[MAG_W-1:0])
                    : (root_value[MAG_W-1:0] - norm_u_ff);

   always_comb begin
      state_in     = state_ff;
      coord_in     = coord_ff;
      last_in      = last_ff;
      point_in     = point_ff;
      axis_in      = axis_ff;
      prod_in      = prod_ff;
      nsq_in       = nsq_ff;
      norm_u_in    = norm_u_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      bound_in     = bound_ff;
      rsp_bound_in = rsp_bound_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      root_cmd     = '0;
      root_operand = '0;
      div_start    = 1'b0;
      mul_a        = coord_mag(coord_ff[coord_sel]);

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               coord_in[0] = req_ref_x;
               coord_in[1] = req_ref_y;
               coord_in[2] = req_ref_z;
               coord_in[3] = req_cand_x;
               coord_in[4] = req_cand_y;
               coord_in[5] = req_cand_z;
               last_in     = req_last_atom;
               point_in    = 1'b0;
               axis_in     = 2'd0;
               nsq_in      = '0;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_a);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            // three squares of at most 2^38 each, so the norm square stays below 2^40
            nsq_in = nsq_ff + prod_ff;
            if (axis_ff == 2'd2) begin
               state_in = ST_ROOT_GO;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_ROOT_GO: begin
            root_cmd.start     = 1'b1;
            root_cmd.long_mode = 1'b0;
            root_operand       = SUM_W'(nsq_ff);
            state_in           = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (root_done) begin
               if (!point_ff) begin
                  norm_u_in = root_value[MAG_W-1:0];
                  point_in  = 1'b1;
                  axis_in   = 2'd0;
                  nsq_in    = '0;
                  state_in  = ST_MUL;
               end else begin
                  state_in  = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            // root unit holds the candidate norm until its next start
            mul_a    = norm_diff;
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_a);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (count_ff < COUNT_W'(MAX_ATOMS)) begin
               sum_in   = sum_ff + SUM_W'(prod_ff);
               count_in = count_ff + COUNT_W'(1);
            end else begin
               ovf_in = 1'b1;   // run too long, pair dropped
            end
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            if (count_ff != '0) begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end else begin
               bound_in  = '0;   // empty run
               state_in  = ST_OUT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               root_cmd.start     = 1'b1;
               root_cmd.long_mode = 1'b1;
               root_operand       = div_quot;
               state_in           = ST_MEAN_ROOT;
            end
         end
         ST_MEAN_ROOT: begin
            if (root_done) begin
               bound_in = root_value[BOUND_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the result register once any earlier result has gone
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_bound_in = bound_ff;
               rsp_count_in = count_ff;
               rsp_ovf_in   = ovf_ff;
               sum_in       = '0;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      coord_ff     <= coord_in;
      last_ff      <= last_in;
      point_ff     <= point_in;
      axis_ff      <= axis_in;
      prod_ff      <= prod_in;
      nsq_ff       <= nsq_in;
      norm_u_ff    <= norm_u_in;
      bound_ff     <= bound_in;
      rsp_bound_ff <= rsp_bound_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bound_value = rsp_bound_ff;
   assign rsp_atoms_used  = rsp_count_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

   // the pair count never runs past the run limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_ATOMS))
      else $error("pair count above limit");

   // a new result appears only out of the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");

   // the run state is cleared in the cycle after a result is loaded
   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && state_in == ST_IDLE) |=> (count_ff == '0 && !ovf_ff))
      else $error("run state not cleared after result");

endmodule

`default_nettype wire

>>> rtl/core/rlbn_sqrt.sv
// shared bit-serial floored square root, two operand bits per cycle
// depends on rlbn_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlbn_sqrt import rlbn_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire root_cmd_type       cmd,
   input  wire logic [SUM_W-1:0]   operand,
   output logic                    done,
   output logic [ROOT_W-1:0]       root
);

   logic [SUM_W-1:0]  op_ff,   op_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              run_ff,  run_in;
   logic              done_ff, done_in;

   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;

   always_comb begin
      rem_shift = {rem_ff[REM_W-3:0], op_ff[SUM_W-1 -: 2]};
      trial     = REM_W'({root_ff, 2'b01});

      op_in    = op_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      steps_in = steps_ff;
      run_in   = run_ff;
      done_in  = 1'b0;

      if (cmd.start) begin
         // short operands are left-aligned so both modes consume from the top
         op_in    = cmd.long_mode ? operand : (operand << SHORT_SHIFT);
         rem_in   = '0;
         root_in  = '0;
         steps_in = cmd.long_mode ? STEP_W'(LONG_STEPS) : STEP_W'(SHORT_STEPS);
         run_in   = 1'b1;
      end else if (run_ff) begin
         op_in = {op_ff[SUM_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         steps_in = steps_ff - STEP_W'(1);
         if (steps_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      steps_ff <= steps_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

>>> rtl/core/rlbn_div.sv
// restoring divider, one quotient bit per cycle, for the mean of the squared differences
// depends on rlbn_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlbn_div import rlbn_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [SUM_W-1:0]   dividend,
   input  wire logic [COUNT_W-1:0] divisor,
   output logic                    done,
   output logic [SUM_W-1:0]        quotient
);

   logic [SUM_W-1:0]      q_ff,    q_in;
   logic [COUNT_W-1:0]    rem_ff,  rem_in;
   logic [COUNT_W-1:0]    dvs_ff,  dvs_in;
   logic [DIV_STEP_W-1:0] steps_ff, steps_in;
   logic                  run_ff,  run_in;
   logic                  done_ff, done_in;

   logic [COUNT_W:0]      shifted;
   logic [COUNT_W:0]      diff;

   always_comb begin
      shifted = {rem_ff, q_ff[SUM_W-1]};
      diff    = shifted - {1'b0, dvs_ff};

      q_in     = q_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      steps_in = steps_ff;
      run_in   = run_ff;
      done_in  = 1'b0;

      if (start) begin
         q_in     = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
         steps_in = DIV_STEP_W'(SUM_W);
         run_in   = 1'b1;
      end else if (run_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[COUNT_W-1:0];
            q_in   = {q_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[COUNT_W-1:0];
            q_in   = {q_ff[SUM_W-2:0], 1'b0};
         end
         steps_in = steps_ff - DIV_STEP_W'(1);
         if (steps_ff == DIV_STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      steps_ff <= steps_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire
